// File: rtl/bsce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsce_pkg
// Shared types, constants and the CRC-8 update function for the
// byte-stuffed frame encoder.
// ----------------------------------------------------------------------------
package bsce_pkg;

	// register reset values
	localparam logic [7:0] HEADER_RST = 8'hAC;
	localparam logic [7:0] FOOTER_RST = 8'hAD;
	localparam logic [7:0] ESCAPE_RST = 8'hAE;
	localparam logic [7:0] MASK_RST   = 8'h80;

	// closing byte of every frame
	localparam logic [7:0] CLOSE_BYTE = 8'hFF;
	localparam logic [7:0] CRC_INIT   = 8'h00;

	// reflected CRC-8/Maxim shift constant
	localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

	// configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOOTER = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 8'd3;

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = QAW + 1;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_byte;
	} payload_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
	} line_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] footer_byte;
		logic [7:0] escape_byte;
		logic [7:0] escape_mask;
	} cfg_t;

	// one classified payload byte, ready for the back end
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] crc;
		logic       open;
		logic       esc_data;
		logic       last;
		logic       esc_crc;
	} cmd_t;

	// output steps of one command
	typedef enum logic [6:0] {
		ST_HDR  = 7'b0000001,
		ST_ESCD = 7'b0000010,
		ST_DATA = 7'b0000100,
		ST_ESCC = 7'b0001000,
		ST_CRC  = 7'b0010000,
		ST_FTR  = 7'b0100000,
		ST_END  = 7'b1000000
	} step_t;

	// bitwise reflected CRC-8 over one byte
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFL;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// true when a byte collides with a delimiter or the escape
	function automatic logic needs_escape(input logic [7:0] b, input cfg_t cfg);
		return (b == cfg.header_byte) || (b == cfg.footer_byte) || (b == cfg.escape_byte);
	endfunction

endpackage
`default_nettype wire

// File: rtl/byte_stuffed_crc8_frame_encoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stuffed_crc8_frame_encoder_unit
// Frames payload bytes with header, byte stuffing, CRC-8/Maxim and footer.
// ----------------------------------------------------------------------------
// Payload bytes go in through a push/full queue port, the last byte of a
// message marked; framed line bytes come out through an empty/pop port, one
// byte per cycle unless the line side stalls. A payload byte produces 1
// line byte, or 2 when escaped, plus 1 for the header at frame start and
// 3 to 4 for CRC, footer and closing 0xFF after the last byte, so 1 to 7
// line bytes in all; the back-end sequencer emits them one at a time. A
// four-entry command queue lets input be taken while output
// is stalled. Registers 0 to 3 (header, footer, escape, mask) are written
// through the cfg port, which is always ready; write them only while idle.
// ----------------------------------------------------------------------------
module byte_stuffed_crc8_frame_encoder_unit import bsce_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// payload side
	input  wire logic                 push,
	input  wire payload_t             payload,
	output logic                      full,
	// line side
	output logic                      empty,
	output line_t                     line,
	input  wire logic                 pop,
	// configuration
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	cfg_t cfg_q;
	cmd_t front_cmd;
	cmd_t head;
	logic take;
	logic q_full;
	logic q_empty;
	logic head_done;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign take      = push && !q_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte <= HEADER_RST;
			cfg_q.footer_byte <= FOOTER_RST;
			cfg_q.escape_byte <= ESCAPE_RST;
			cfg_q.escape_mask <= MASK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HEADER: cfg_q.header_byte <= cfg_data;
				CFG_FOOTER: cfg_q.footer_byte <= cfg_data;
				CFG_ESCAPE: cfg_q.escape_byte <= cfg_data;
				CFG_MASK:   cfg_q.escape_mask <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bsce_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.payload (payload),
		.cfg     (cfg_q),
		.cmd     (front_cmd)
	);

	bsce_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (take),
		.wr_cmd  (front_cmd),
		.rd      (head_done),
		.head    (head),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	bsce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (~q_empty),
		.cfg        (cfg_q),
		.head_done  (head_done),
		.line       (line),
		.empty      (empty),
		.pop        (pop)
	);

endmodule
`default_nettype wire

// File: rtl/bsce_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsce_front
// Accepts payload bytes, keeps frame state and the running CRC, and turns
// each byte into a command for the back end.
// ----------------------------------------------------------------------------
module bsce_front import bsce_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     take,
	input  wire payload_t payload,
	input  wire cfg_t     cfg,
	output cmd_t          cmd
);

	logic       inside_frame_q;
	logic [7:0] crc_q;
	logic [7:0] crc_base;
	logic [7:0] crc_new;

	// new frame restarts the CRC
	assign crc_base = inside_frame_q ? crc_q : CRC_INIT;
	assign crc_new  = crc8_update(crc_base, payload.payload_byte);

	// classify the byte
	always_comb begin
		cmd.data     = payload.payload_byte;
		cmd.crc      = crc_new;
		cmd.open     = ~inside_frame_q;
		cmd.esc_data = needs_escape(payload.payload_byte, cfg);
		cmd.last     = payload.last_byte;
		cmd.esc_crc  = needs_escape(crc_new, cfg);
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_frame_q <= 1'b0;
			crc_q          <= CRC_INIT;
		end else if (take) begin
			if (payload.last_byte) begin
				inside_frame_q <= 1'b0;
				crc_q          <= CRC_INIT;
			end else begin
				inside_frame_q <= 1'b1;
				crc_q          <= crc_new;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/bsce_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsce_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bsce_queue import bsce_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire cmd_t wr_cmd,
	input  wire logic rd,
	output cmd_t      head,
	output logic      q_full,
	output logic      q_empty
);

	localparam logic [QCW-1:0] QFULL = QCW'(QDEPTH);

	cmd_t           slot_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign head    = slot_q[rd_ptr_q];
	assign q_full  = (count_q == QFULL);
	assign q_empty = (count_q == '0);

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/bsce_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsce_back
// Sequencer that expands each command into line bytes, one per cycle unless
// the line side stalls, into an output register.
// ----------------------------------------------------------------------------
module bsce_back import bsce_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t head,
	input  wire logic head_valid,
	input  wire cfg_t cfg,
	output logic      head_done,
	output line_t     line,
	output logic      empty,
	input  wire logic pop
);

	step_t      step_q;
	logic       fresh_q;
	logic       out_valid_q;
	line_t      line_q;

	step_t      start;
	step_t      cur;
	step_t      nxt;
	logic [7:0] byte_v;
	logic       end_v;
	logic       done_v;
	logic       advance;

	// first step of a command
	always_comb begin
		if (head.open) begin
			start = ST_HDR;
		end else if (head.esc_data) begin
			start = ST_ESCD;
		end else begin
			start = ST_DATA;
		end
	end

	assign cur     = fresh_q ? start : step_q;
	assign advance = head_valid && (!out_valid_q || pop);

	// byte of the current step and the step after it
	always_comb begin
		byte_v = 8'h00;
		end_v  = 1'b0;
		done_v = 1'b0;
		nxt    = ST_HDR;
		unique case (cur)
			ST_HDR: begin
				byte_v = cfg.header_byte;
				nxt    = head.esc_data ? ST_ESCD : ST_DATA;
			end
			ST_ESCD: begin
				byte_v = cfg.escape_byte;
				nxt    = ST_DATA;
			end
			ST_DATA: begin
				byte_v = head.esc_data ? (head.data ^ cfg.escape_mask) : head.data;
				done_v = ~head.last;
				nxt    = head.esc_crc ? ST_ESCC : ST_CRC;
			end
			ST_ESCC: begin
				byte_v = cfg.escape_byte;
				nxt    = ST_CRC;
			end
			ST_CRC: begin
				byte_v = head.esc_crc ? (head.crc ^ cfg.escape_mask) : head.crc;
				nxt    = ST_FTR;
			end
			ST_FTR: begin
				byte_v = cfg.footer_byte;
				nxt    = ST_END;
			end
			ST_END: begin
				byte_v = CLOSE_BYTE;
				end_v  = 1'b1;
				done_v = 1'b1;
			end
			default: begin
				done_v = 1'b1;
			end
		endcase
	end

	assign head_done = advance && done_v;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_HDR;
			fresh_q <= 1'b1;
		end else if (advance) begin
			fresh_q <= done_v;
			step_q  <= nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			line_q.out_byte  <= byte_v;
			line_q.frame_end <= end_v;
		end
	end

	assign line  = line_q;
	assign empty = ~out_valid_q;

endmodule
`default_nettype wire

// File: tb/sv/byte_stuffed_crc8_frame_encoder_unit_tb.sv
// ----------------------------------------------------------------------------
// byte_stuffed_crc8_frame_encoder_unit_tb
// Self-checking bench for the byte-stuffed CRC-8 frame encoder.
// ----------------------------------------------------------------------------
// Payload requests are pushed with random gaps and line bytes are popped
// with random stalls. A line-side monitor keeps its own copy of the framing
// state (open frame, running CRC-8/Maxim, four registers), builds the line
// bytes each accepted payload request should give, and compares every popped
// byte field by field in order. A short directed pass covers extreme bytes,
// delimiter collisions in data and CRC, and register corner settings; random
// frames then run under several register settings, the extremes included.
// ----------------------------------------------------------------------------
module byte_stuffed_crc8_frame_encoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bsce_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES    = 40;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_ITEMS    = 75;

	// indexes outside the register map, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW = 8'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = 8'hFF;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 push      = 1'b0;
	payload_t             payload   = '0;
	logic                 full;
	logic                 empty;
	line_t                line;
	logic                 pop       = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data  = '0;

	// framing state as the encoder should hold it
	logic [7:0] hdr_reg    = HEADER_RST;
	logic [7:0] ftr_reg    = FOOTER_RST;
	logic [7:0] esc_reg    = ESCAPE_RST;
	logic [7:0] msk_reg    = MASK_RST;
	logic       frame_open = 1'b0;
	logic [7:0] crc_acc    = CRC_INIT;

	line_t line_expect[$];
	int    fault_count = 0;
	int    stall_count = 0;
	int    lines_seen  = 0;

	byte_stuffed_crc8_frame_encoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.payload   (payload),
		.full      (full),
		.empty     (empty),
		.line      (line),
		.pop       (pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// reflected CRC-8/Maxim, one byte
	function automatic logic [7:0] crc8_maxim_next(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
		return r;
	endfunction

	// single-byte frame whose CRC lands on the given value
	function automatic logic [7:0] byte_for_crc(input logic [7:0] target);
		logic [7:0] found;
		found = 8'h00;
		for (int v = 0; v < 256; v++) begin
			if (crc8_maxim_next(CRC_INIT, 8'(v)) == target) begin
				found = 8'(v);
			end
		end
		return found;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 94) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic void report_fault(input string text);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%s", text);
		end
	endfunction

	function automatic void expect_line(input logic [7:0] b, input logic fe);
		line_t l;
		l.out_byte  = b;
		l.frame_end = fe;
		line_expect.push_back(l);
	endfunction

	// data and CRC bytes that collide with a delimiter go out escaped
	function automatic void expect_stuffed(input logic [7:0] b);
		if (b == hdr_reg || b == ftr_reg || b == esc_reg) begin
			expect_line(esc_reg, 1'b0);
			expect_line(b ^ msk_reg, 1'b0);
		end else begin
			expect_line(b, 1'b0);
		end
	endfunction

	// line bytes caused by one payload request
	function automatic void predict_frame_bytes(input payload_t p);
		if (!frame_open) begin
			expect_line(hdr_reg, 1'b0);
			frame_open = 1'b1;
			crc_acc    = CRC_INIT;
		end
		crc_acc = crc8_maxim_next(crc_acc, p.payload_byte);
		expect_stuffed(p.payload_byte);
		if (p.last_byte) begin
			expect_stuffed(crc_acc);
			expect_line(ftr_reg, 1'b0);
			expect_line(CLOSE_BYTE, 1'b1);
			frame_open = 1'b0;
			crc_acc    = CRC_INIT;
		end
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		case (idx)
			CFG_HEADER: hdr_reg = value;
			CFG_FOOTER: ftr_reg = value;
			CFG_ESCAPE: esc_reg = value;
			CFG_MASK:   msk_reg = value;
			default: ;
		endcase
	endfunction

	// accepted requests on all three ports, checks and watchdog
	always @(posedge clk) begin : line_monitor
		line_t want;
		logic  moved;
		if (arst_n) begin
			moved = 1'b0;
			if (push && !full) begin
				predict_frame_bytes(payload);
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				apply_register(cfg_index, cfg_data);
				moved = 1'b1;
			end
			if (pop && !empty) begin
				moved = 1'b1;
				lines_seen++;
				if (line_expect.size() == 0) begin
					report_fault($sformatf("line %0d: out_byte %h frame_end %b, none expected",
						lines_seen, line.out_byte, line.frame_end));
				end else begin
					want = line_expect.pop_front();
					if (line.out_byte !== want.out_byte) begin
						report_fault($sformatf("line %0d: out_byte expected %h got %h",
							lines_seen, want.out_byte, line.out_byte));
					end
					if (line.frame_end !== want.frame_end) begin
						report_fault($sformatf("line %0d: frame_end expected %b got %b",
							lines_seen, want.frame_end, line.frame_end));
					end
				end
			end
			stall_count = moved ? 0 : stall_count + 1;
			if (stall_count >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// line side: random stalls with the odd long steady run
	initial begin : line_drain
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			hold = pick_gap();
			if (hold != 0) begin
				pop <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			pop <= 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(30, 80)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// push stays high on return so back-to-back requests need no toggle
	task automatic push_payload(input logic [7:0] value, input logic ends_frame, input logic steady);
		payload_t    item;
		int unsigned gap;
		item.payload_byte = value;
		item.last_byte    = ends_frame;
		gap = steady ? 0 : pick_gap();
		cfg_valid <= 1'b0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		payload <= item;
		do @(posedge clk); while (full);
	endtask

	// drop requests and wait until every expected line byte has been popped
	task automatic wait_drained();
		push      <= 1'b0;
		cfg_valid <= 1'b0;
		do @(posedge clk); while (line_expect.size() != 0);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_registers(input logic [7:0] h, input logic [7:0] f,
			input logic [7:0] e, input logic [7:0] m);
		write_register(CFG_HEADER, h);
		write_register(CFG_FOOTER, f);
		write_register(CFG_ESCAPE, e);
		write_register(CFG_MASK, m);
	endtask

	// extreme payload values under reset settings
	task automatic test_plain_frames();
		push_payload(8'h00, 1'b1, 1'b0);
		push_payload(8'hFF, 1'b1, 1'b0);
		push_payload(8'h00, 1'b0, 1'b0);
		push_payload(8'hFF, 1'b0, 1'b0);
		push_payload(8'h7F, 1'b0, 1'b0);
		push_payload(8'h80, 1'b1, 1'b0);
	endtask

	// delimiters in the data, then CRCs that land on each delimiter
	task automatic test_delimiter_data();
		push_payload(hdr_reg, 1'b0, 1'b0);
		push_payload(ftr_reg, 1'b0, 1'b0);
		push_payload(esc_reg, 1'b1, 1'b0);
		push_payload(byte_for_crc(hdr_reg), 1'b1, 1'b1);
		push_payload(byte_for_crc(ftr_reg), 1'b1, 1'b0);
		push_payload(byte_for_crc(esc_reg), 1'b1, 1'b1);
	endtask

	task automatic test_register_corners();
		// writes outside the map leave the settings alone
		write_register(CFG_UNUSED_TOP, 8'hFF);
		write_register(CFG_UNUSED_LOW, 8'h00);
		push_payload(HEADER_RST, 1'b1, 1'b0);
		// zero mask: prefix then the unchanged byte
		write_register(CFG_MASK, 8'h00);
		push_payload(ESCAPE_RST, 1'b0, 1'b0);
		push_payload(FOOTER_RST, 1'b1, 1'b0);
		// escaped value lands on the other delimiter, sent as is
		write_register(CFG_MASK, 8'h01);
		push_payload(HEADER_RST, 1'b0, 1'b0);
		push_payload(FOOTER_RST, 1'b1, 1'b1);
		// all three delimiters the same
		load_registers(8'h5A, 8'h5A, 8'h5A, MASK_RST);
		push_payload(8'h5A, 1'b0, 1'b0);
		push_payload(8'h00, 1'b1, 1'b0);
		// header changed while a frame is open
		load_registers(HEADER_RST, FOOTER_RST, ESCAPE_RST, MASK_RST);
		push_payload(8'h11, 1'b0, 1'b0);
		write_register(CFG_HEADER, 8'h11);
		push_payload(8'h11, 1'b0, 1'b0);
		push_payload(8'h33, 1'b1, 1'b0);
	endtask

	// random frames under several settings, data biased towards collisions
	task automatic test_random_frames();
		int unsigned sent;
		int unsigned frame_len;
		int unsigned k;
		int unsigned roll;
		logic [7:0]  h;
		logic [7:0]  value;
		logic        steady;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: load_registers(HEADER_RST, FOOTER_RST, ESCAPE_RST, MASK_RST);
				1: load_registers(8'h00, 8'h00, 8'h00, 8'h00);
				2: load_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
				3: load_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				4: begin
					h = 8'($urandom_range(0, 255));
					load_registers(h, h, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				end
				default: load_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'h00);
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					frame_len = $urandom_range(1, 4);
				end else if (roll < 95) begin
					frame_len = $urandom_range(5, 12);
				end else begin
					frame_len = $urandom_range(13, 40);
				end
				steady = ($urandom_range(0, 3) == 0);
				for (k = 0; k < frame_len && sent < PHASE_ITEMS; k++) begin
					roll = $urandom_range(0, 99);
					case (roll % 10)
						0: value = hdr_reg;
						1: value = ftr_reg;
						2: value = esc_reg;
						3: value = (roll < 50) ? (hdr_reg ^ msk_reg) : 8'hFF;
						default: value = 8'($urandom_range(0, 255));
					endcase
					push_payload(value, k == frame_len - 1, steady);
					sent++;
					// occasional register change inside an open frame
					if (k != frame_len - 1 && $urandom_range(0, 49) == 0) begin
						write_register(CFG_IDX_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
					end
				end
			end
		end
	endtask

	initial begin : run_tests
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_plain_frames();
		test_delimiter_data();
		test_register_corners();
		test_random_frames();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0 && line_expect.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
